// ===== rtl/bcpg_pkg.sv =====
package bcpg_pkg;

    localparam int COORD_W        = 32;
    localparam int FRAC_W         = 16;
    localparam int IDX_W          = 10;
    localparam int STEPS_W        = 10;
    localparam int T_W            = FRAC_W + 1;
    localparam int POINT_W        = 3 * COORD_W;
    localparam int MAX_POINTS_DEF = 16;
    localparam int STEPS_RESET    = 100;

    // restoring division of (index << 16) by steps, one quotient bit a cycle
    localparam int DIV_STEPS = IDX_W + FRAC_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS);
    // read, difference, product: cycles before the last write of a level lands
    localparam int DRAIN_CYC = 3;

    typedef enum logic [2:0] {
        ST_VALID  = 3'd0,
        ST_LOADED = 3'd1,
        ST_FULL   = 3'd2,
        ST_EMPTY  = 3'd3,
        ST_RANGE  = 3'd4
    } t_status;

    typedef struct packed {
        logic                      kind;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
        logic                      first_point;
        logic [IDX_W-1:0]          sample_index;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] curve_x;
        logic signed [COORD_W-1:0] curve_y;
        logic signed [COORD_W-1:0] curve_z;
        t_status                   status;
    } t_out_item;

    typedef struct packed {
        logic    cp_we;
        logic    div_load;
        logic    div_step;
        logic    rd_en;
        logic    rd_wk;
        logic    pair;
        logic    cap;
        logic    out_load;
        t_status out_status;
    } t_dp_cmd;

    typedef struct packed {
        logic range_err;
    } t_dp_stat;

endpackage

// ===== rtl/bcpg_ram.sv =====
module bcpg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/bcpg_ctrl.sv =====
module bcpg_ctrl import bcpg_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_kind,
    input  logic                          i_first,
    input  logic                          i_out_stall,
    input  t_dp_stat                      i_stat,
    output t_dp_cmd                       o_cmd,
    output logic [$clog2(MAX_POINTS)-1:0] o_cp_waddr,
    output logic [$clog2(MAX_POINTS)-1:0] o_rd_addr,
    output logic                          o_in_stall,
    output logic                          o_out_valid
);

    localparam int ADDR_W = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_LVL_RD,
        S_DRAIN,
        S_FIN_RD,
        S_FIN_WAIT,
        S_OUT
    } t_state;

    t_state              r_state,     n_state;
    logic [CNT_W-1:0]    r_count,     n_count;
    logic [ADDR_W-1:0]   r_lvl,       n_lvl;
    logic [ADDR_W-1:0]   r_addr,      n_addr;
    logic [DCNT_W-1:0]   r_dcnt,      n_dcnt;
    logic                r_wk,        n_wk;
    t_status             r_status,    n_status;
    logic                r_out_valid, n_out_valid;

    logic [CNT_W-1:0]    cnt_eff;
    logic [CNT_W-1:0]    cnt_m1;
    logic                out_free;

    assign cnt_eff  = i_first ? '0 : r_count;
    assign cnt_m1   = r_count - CNT_W'(1);
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_lvl       = r_lvl;
        n_addr      = r_addr;
        n_dcnt      = r_dcnt;
        n_wk        = r_wk;
        n_status    = r_status;
        n_out_valid = (r_out_valid && !i_out_stall) ? 1'b0 : r_out_valid;
        o_cmd            = '0;
        o_cmd.out_status = r_status;
        o_cp_waddr       = cnt_eff[ADDR_W-1:0];
        o_rd_addr        = r_addr;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (!i_kind) begin
                        n_state = S_OUT;
                        if (cnt_eff >= CNT_W'(MAX_POINTS)) begin
                            n_count  = cnt_eff;
                            n_status = ST_FULL;
                        end else begin
                            o_cmd.cp_we = 1'b1;
                            n_count     = cnt_eff + CNT_W'(1);
                            n_status    = ST_LOADED;
                        end
                    end else begin
                        n_wk = 1'b0;
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_OUT;
                        end else if (i_stat.range_err) begin
                            n_status = ST_RANGE;
                            n_state  = S_OUT;
                        end else begin
                            o_cmd.div_load = 1'b1;
                            n_dcnt         = '0;
                            n_state        = S_DIV;
                        end
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_dcnt         = r_dcnt + DCNT_W'(1);
                if (r_dcnt == DCNT_W'(DIV_STEPS - 1)) begin
                    n_lvl  = cnt_m1[ADDR_W-1:0];
                    n_addr = '0;
                    // a lone point is the curve itself
                    n_state = (r_count == CNT_W'(1)) ? S_FIN_RD : S_LVL_RD;
                end
            end
            S_LVL_RD: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.rd_wk = r_wk;
                o_cmd.pair  = (r_addr != '0);
                if (r_addr == r_lvl) begin
                    n_dcnt  = '0;
                    n_state = S_DRAIN;
                end else begin
                    n_addr = r_addr + ADDR_W'(1);
                end
            end
            S_DRAIN: begin
                n_dcnt = r_dcnt + DCNT_W'(1);
                if (r_dcnt == DCNT_W'(DRAIN_CYC - 1)) begin
                    n_wk   = 1'b1;
                    n_addr = '0;
                    if (r_lvl == ADDR_W'(1)) begin
                        n_state = S_FIN_RD;
                    end else begin
                        n_lvl   = r_lvl - ADDR_W'(1);
                        n_state = S_LVL_RD;
                    end
                end
            end
            S_FIN_RD: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.rd_wk = r_wk;
                o_cmd.cap   = 1'b1;
                o_rd_addr   = '0;
                n_state     = S_FIN_WAIT;
            end
            S_FIN_WAIT: begin
                n_status = ST_VALID;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_lvl       <= '0;
            r_addr      <= '0;
            r_dcnt      <= '0;
            r_wk        <= 1'b0;
            r_status    <= ST_VALID;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_lvl       <= n_lvl;
            r_addr      <= n_addr;
            r_dcnt      <= n_dcnt;
            r_wk        <= n_wk;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/bcpg_dp.sv =====
module bcpg_dp import bcpg_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_in_item                      i_in,
    input  logic                          i_cfg_we,
    input  logic [STEPS_W-1:0]            i_cfg_data,
    input  t_dp_cmd                       i_cmd,
    input  logic [$clog2(MAX_POINTS)-1:0] i_cp_waddr,
    input  logic [$clog2(MAX_POINTS)-1:0] i_rd_addr,
    output t_dp_stat                      o_stat,
    output t_out_item                     o_out
);

    localparam int ADDR_W = $clog2(MAX_POINTS);
    localparam int DQ_W   = DIV_STEPS;
    localparam int DIFF_W = COORD_W + 1;
    localparam int PROD_W = DIFF_W + T_W + 1;

    // configuration and divider
    logic [STEPS_W-1:0]  r_steps;
    logic [STEPS_W-1:0]  steps_eff;
    logic [STEPS_W-1:0]  r_div;
    logic [STEPS_W-1:0]  r_rem;
    logic [DQ_W-1:0]     r_dq;
    logic [STEPS_W:0]    rem_sh;
    logic                q_bit;
    logic [STEPS_W:0]    rem_nx;
    logic [T_W-1:0]      t_val;

    // memories
    logic [POINT_W-1:0]  cp_rdata;
    logic [POINT_W-1:0]  wk_rdata;
    logic [POINT_W-1:0]  src_data;
    logic [POINT_W-1:0]  wk_wdata;

    // interpolation pipeline
    logic                r_rd0, r_src0, r_v0, r_cap0;
    logic [ADDR_W-1:0]   r_wa0, r_wa1, r_wa2;
    logic                r_v1, r_v2;
    logic signed [COORD_W-1:0] src_c  [3];
    logic signed [COORD_W-1:0] r_prev [3];
    logic signed [COORD_W-1:0] r_p1   [3];
    logic signed [DIFF_W-1:0]  r_d1   [3];
    logic signed [COORD_W-1:0] r_p2   [3];
    logic signed [PROD_W-1:0]  r_prod2 [3];
    logic signed [PROD_W-1:0]  prod_sh [3];
    logic signed [COORD_W-1:0] lerp_c [3];
    logic signed [COORD_W-1:0] r_res  [3];
    t_out_item                 r_out;

    assign steps_eff        = (r_steps == '0) ? STEPS_W'(1) : r_steps;
    assign o_stat.range_err = (i_in.sample_index > steps_eff);

    assign rem_sh = {r_rem, r_dq[DQ_W-1]};
    assign q_bit  = (rem_sh >= {1'b0, r_div});
    assign rem_nx = q_bit ? (rem_sh - {1'b0, r_div}) : rem_sh;
    assign t_val  = r_dq[T_W-1:0];

    bcpg_ram #(
        .WIDTH (POINT_W),
        .DEPTH (MAX_POINTS)
    ) u_cp_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.cp_we),
        .i_waddr (i_cp_waddr),
        .i_wdata ({i_in.point_x, i_in.point_y, i_in.point_z}),
        .i_raddr (i_rd_addr),
        .o_rdata (cp_rdata)
    );

    bcpg_ram #(
        .WIDTH (POINT_W),
        .DEPTH (MAX_POINTS)
    ) u_wk_ram (
        .i_clk   (i_clk),
        .i_we    (r_v2),
        .i_waddr (r_wa2),
        .i_wdata (wk_wdata),
        .i_raddr (i_rd_addr),
        .o_rdata (wk_rdata)
    );

    assign src_data = r_src0 ? wk_rdata : cp_rdata;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            src_c[c]   = src_data[(2 - c) * COORD_W +: COORD_W];
            prod_sh[c] = r_prod2[c] >>> FRAC_W;
            lerp_c[c]  = r_p2[c] + prod_sh[c][COORD_W-1:0];
        end
    end

    assign wk_wdata = {lerp_c[0], lerp_c[1], lerp_c[2]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps <= STEPS_W'(STEPS_RESET);
            r_rd0   <= 1'b0;
            r_v0    <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_cap0  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_steps <= i_cfg_data;
            end
            r_rd0  <= i_cmd.rd_en;
            r_v0   <= i_cmd.rd_en && i_cmd.pair;
            r_v1   <= r_v0;
            r_v2   <= r_v1;
            r_cap0 <= i_cmd.cap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_div <= steps_eff;
            r_rem <= '0;
            r_dq  <= {i_in.sample_index, FRAC_W'(0)};
        end else if (i_cmd.div_step) begin
            r_rem <= rem_nx[STEPS_W-1:0];
            r_dq  <= {r_dq[DQ_W-2:0], q_bit};
        end

        r_src0 <= i_cmd.rd_wk;
        r_wa0  <= i_rd_addr - ADDR_W'(1);
        r_wa1  <= r_wa0;
        r_wa2  <= r_wa1;

        for (int c = 0; c < 3; c++) begin
            if (r_rd0) begin
                r_prev[c] <= src_c[c];
            end
            r_p1[c]    <= r_prev[c];
            r_d1[c]    <= DIFF_W'(src_c[c]) - DIFF_W'(r_prev[c]);
            r_p2[c]    <= r_p1[c];
            r_prod2[c] <= r_d1[c] * $signed({1'b0, t_val});
            if (r_cap0) begin
                r_res[c] <= src_c[c];
            end
        end

        if (i_cmd.out_load) begin
            r_out.status <= i_cmd.out_status;
            if (i_cmd.out_status == ST_VALID) begin
                r_out.curve_x <= r_res[0];
                r_out.curve_y <= r_res[1];
                r_out.curve_z <= r_res[2];
            end else begin
                r_out.curve_x <= '0;
                r_out.curve_y <= '0;
                r_out.curve_z <= '0;
            end
        end
    end

    assign o_out = r_out;

endmodule

// ===== rtl/bezier_curve_point_generator_core.sv =====
// Bezier curve point generator: de Casteljau evaluation in signed Q16.16.
//
// Input channel (i_in_valid / o_in_stall / i_in) carries one item a time.
// A load item (kind 0) appends a control point; first_point empties the list
// first. An evaluate item (kind 1) returns the curve point at
// t = floor(sample_index * 65536 / sample_steps). Every item gives exactly one
// result item on the output channel (o_out_valid / i_out_stall / o_out). The
// user sets sample_steps (i_cfg_we / i_cfg_data) only while idle; not enforced.
//
// An evaluate first runs the bit-serial divider that forms t, then sweeps the
// work memory once per level, then reads the final point. A load or an error
// answer skips these steps. One item is in work at a time.
//
// Reset empties the list and sets sample_steps to 100. A stalled result
// holds in the output register; the next item is still accepted and waits
// to deliver until that register is free.
module bezier_curve_point_generator_core import bcpg_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_item           i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_item          o_out,
    input  logic               i_cfg_we,
    input  logic [STEPS_W-1:0] i_cfg_data
);

    localparam int ADDR_W = $clog2(MAX_POINTS);

    t_dp_cmd           cmd;
    t_dp_stat          stat;
    logic [ADDR_W-1:0] cp_waddr;
    logic [ADDR_W-1:0] rd_addr;

    // sequence the item: accept, divide, sweep levels, deliver
    bcpg_ctrl #(
        .MAX_POINTS (MAX_POINTS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_kind      (i_in.kind),
        .i_first     (i_in.first_point),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_cp_waddr  (cp_waddr),
        .o_rd_addr   (rd_addr),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    // point store, work memory, divider, three interpolation lanes
    bcpg_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .i_cp_waddr (cp_waddr),
        .i_rd_addr  (rd_addr),
        .o_stat     (stat),
        .o_out      (o_out)
    );

    // an accepted item always blocks the input for at least the next cycle
    a_busy_after_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not held off after accept");

    // a result register is loaded only while the input is held off
    a_out_load_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> o_in_stall)
        else $error("result loaded while idle");

    // answers other than a valid point carry zero coordinates
    a_zero_on_status : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status != ST_VALID) |->
            (o_out.curve_x == '0 && o_out.curve_y == '0 && o_out.curve_z == '0))
        else $error("non-zero coordinates on a status answer");

    // status codes stay within the defined set
    a_status_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.status <= ST_RANGE))
        else $error("undefined status code");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import bcpg_pkg::*;

    // Item kinds carried in the kind field of an input item
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_EVAL = 1'b1;

    localparam int LIST_DEPTH   = MAX_POINTS_DEF;
    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYC    = 11;
    // Allow for a full list evaluation with long stalls on top
    localparam int QUIET_LIMIT  = 4000;
    localparam int SETTLE_CYC   = 300;
    localparam int REPORT_MAX   = 10;
    localparam int PHASE_ITEMS  = 190;

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    t_in_item           i_in       = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    t_out_item          o_out;
    logic               i_cfg_we   = 1'b0;
    logic [STEPS_W-1:0] i_cfg_data = '0;

    // Shadow of the block: stored control points, their number and the
    // steps register, kept in step with every accepted item and write
    logic signed [COORD_W-1:0] ctrl_pts [LIST_DEPTH][3];
    int                        list_len;
    logic [STEPS_W-1:0]        steps_reg;

    // Answers predicted for accepted items, oldest first
    t_out_item pending_answers[$];

    int fault_cnt;
    int send_gap_pct;
    int out_stall_pct;
    int quiet_cycles;

    bezier_curve_point_generator_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // A steps value of zero behaves as one
    function automatic int unsigned steps_in_force();
        return (steps_reg == 0) ? 1 : int'(steps_reg);
    endfunction

    // One interpolation step: p + floor((q - p) * t / 2^16), exact product
    function automatic logic signed [COORD_W-1:0] lerp_q16(
        input logic signed [COORD_W-1:0] p,
        input logic signed [COORD_W-1:0] q,
        input int unsigned               t
    );
        logic signed [63:0] ps;
        logic signed [63:0] qs;
        logic signed [63:0] tw;
        logic signed [63:0] sum;
        ps  = p;
        qs  = q;
        tw  = t;
        sum = ps + (((qs - ps) * tw) >>> FRAC_W);
        return sum[COORD_W-1:0];
    endfunction

    // Work out the answer to one accepted item and advance the shadow list
    function automatic t_out_item predict_answer(input t_in_item it);
        t_out_item                 ans;
        logic signed [COORD_W-1:0] work [LIST_DEPTH][3];
        int unsigned               t;
        ans = '0;
        if (it.kind == KIND_LOAD) begin
            if (it.first_point)
                list_len = 0;
            if (list_len >= LIST_DEPTH) begin
                ans.status = ST_FULL;
            end else begin
                ctrl_pts[list_len][0] = it.point_x;
                ctrl_pts[list_len][1] = it.point_y;
                ctrl_pts[list_len][2] = it.point_z;
                list_len++;
                ans.status = ST_LOADED;
            end
        end else if (list_len == 0) begin
            ans.status = ST_EMPTY;
        end else if (it.sample_index > steps_in_force()) begin
            ans.status = ST_RANGE;
        end else begin
            t    = {it.sample_index, {FRAC_W{1'b0}}} / steps_in_force();
            work = ctrl_pts;
            // Reduce one level at a time until a single point is left
            for (int lvl = list_len - 1; lvl > 0; lvl--)
                for (int k = 0; k < lvl; k++)
                    for (int c = 0; c < 3; c++)
                        work[k][c] = lerp_q16(work[k][c], work[k+1][c], t);
            ans.curve_x = work[0][0];
            ans.curve_y = work[0][1];
            ans.curve_z = work[0][2];
            ans.status  = ST_VALID;
        end
        return ans;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic report_fault(input string what, input t_out_item want,
                                input t_out_item got);
        fault_cnt++;
        if (fault_cnt <= REPORT_MAX)
            $display("%0t: %s: expected x=%h y=%h z=%h st=%0d, got x=%h y=%h z=%h st=%0d",
                     $realtime, what, want.curve_x, want.curve_y, want.curve_z,
                     want.status, got.curve_x, got.curve_y, got.curve_z, got.status);
    endtask

    // Compare each result item taken from the block with the oldest answer
    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_answers.size() == 0) begin
                report_fault("result with nothing pending", '0, o_out);
            end else begin
                want = pending_answers.pop_front();
                if (o_out.curve_x !== want.curve_x || o_out.curve_y !== want.curve_y ||
                    o_out.curve_z !== want.curve_z || o_out.status !== want.status)
                    report_fault("result mismatch", want, o_out);
            end
        end
    end

    // Stall the result channel at the rate of the current phase
    always @(negedge i_clk)
        i_out_stall <= ($urandom_range(99) < out_stall_pct);

    // End the run once nothing has moved on either channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: nothing accepted for %0d cycles", QUIET_LIMIT);
            $display("[bezier_curve_point_generator_core] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mix the corners of Q16.16 with small and fully random values
    function automatic logic signed [COORD_W-1:0] pick_coord();
        case ($urandom_range(7))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return 32'(int'($urandom_range(1 << 21)) - (1 << 20));
            default: return $urandom;
        endcase
    endfunction

    // Load item; the sample index is ignored, so fill it with noise
    function automatic t_in_item make_load(input logic signed [COORD_W-1:0] x,
                                           input logic signed [COORD_W-1:0] y,
                                           input logic signed [COORD_W-1:0] z,
                                           input logic first);
        t_in_item it;
        it.kind         = KIND_LOAD;
        it.point_x      = x;
        it.point_y      = y;
        it.point_z      = z;
        it.first_point  = first;
        it.sample_index = IDX_W'($urandom_range(1023));
        return it;
    endfunction

    // Evaluate item; point fields and the first flag are ignored
    function automatic t_in_item make_eval(input int unsigned idx);
        t_in_item it;
        it.kind         = KIND_EVAL;
        it.point_x      = $urandom;
        it.point_y      = $urandom;
        it.point_z      = $urandom;
        it.first_point  = 1'($urandom_range(1));
        it.sample_index = IDX_W'(idx);
        return it;
    endfunction

    // Drive one item from the falling edge, hold it until the block takes it
    // and then record what the block must answer
    task automatic push_item(input t_in_item it);
        @(negedge i_clk);
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in       = it;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        pending_answers.push_back(predict_answer(it));
    endtask

    // Let every pending answer come back, then write the steps register
    task automatic write_steps(input logic [STEPS_W-1:0] value);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_answers.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        steps_reg  = value;
    endtask

    task automatic set_idling(input int gap_pct, input int stall_pct);
        send_gap_pct  = gap_pct;
        out_stall_pct = stall_pct;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Evaluate with no points; the empty check wins over a bad index
    task automatic test_empty_list();
        push_item(make_eval(0));
        push_item(make_eval(1023));
    endtask

    // One point: t at both ends returns that point; one past steps is refused
    task automatic test_single_point();
        push_item(make_load(32'sh7FFF_FFFF, 32'sh8000_0000, -32'sd1, 1'b1));
        push_item(make_eval(0));
        push_item(make_eval(steps_in_force()));
        push_item(make_eval(steps_in_force() + 1));
    endtask

    // Fill the list to the brim with corner x and y values, overflow it, evaluate
    task automatic test_full_list();
        for (int i = 1; i < LIST_DEPTH; i++)
            push_item(make_load(i[0] ? 32'sh7FFF_FFFF : 32'sh8000_0000,
                                i[1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF,
                                pick_coord(), 1'b0));
        push_item(make_load(pick_coord(), pick_coord(), pick_coord(), 1'b0));
        push_item(make_eval(0));
        push_item(make_eval(steps_in_force() / 3));
        push_item(make_eval(steps_in_force()));
    endtask

    // The first-point flag must restart a full list
    task automatic test_restart();
        push_item(make_load(pick_coord(), pick_coord(), pick_coord(), 1'b1));
        push_item(make_load(pick_coord(), pick_coord(), pick_coord(), 1'b0));
        push_item(make_eval(1));
    endtask

    // Steps of zero acts as one: index 1 is the far end, 2 is out of range
    task automatic test_zero_steps();
        write_steps('0);
        push_item(make_eval(1));
        push_item(make_eval(2));
    endtask

    // Curves of random shape: mostly a restart, a few loads and several
    // evaluations, with the odd overfilled list and stray item among them
    task automatic test_random_curves(input int gap_pct, input int stall_pct,
                                      input logic [STEPS_W-1:0] steps);
        int          sent;
        int          n_pts;
        int unsigned top;
        t_in_item    stray;
        set_idling(gap_pct, stall_pct);
        write_steps(steps);
        top  = steps_in_force();
        sent = 0;
        while (sent < PHASE_ITEMS) begin
            if ($urandom_range(9) == 0) begin
                stray.kind         = 1'($urandom_range(1));
                stray.point_x      = $urandom;
                stray.point_y      = $urandom;
                stray.point_z      = $urandom;
                stray.first_point  = ($urandom_range(3) == 0);
                stray.sample_index = IDX_W'($urandom_range(1023));
                push_item(stray);
                sent++;
            end else begin
                // keep most lists short, since evaluation time grows with n^2
                case ($urandom_range(19))
                    0:       n_pts = $urandom_range(LIST_DEPTH + 1, LIST_DEPTH + 2);
                    1, 2:    n_pts = $urandom_range(6, LIST_DEPTH);
                    default: n_pts = $urandom_range(1, 5);
                endcase
                for (int i = 0; i < n_pts; i++)
                    push_item(make_load(pick_coord(), pick_coord(), pick_coord(), i == 0));
                sent += n_pts;
                repeat ($urandom_range(1, 6)) begin
                    if ($urandom_range(7) == 0 && top < 1023)
                        push_item(make_eval($urandom_range(top + 1, 1023)));
                    else
                        push_item(make_eval($urandom_range(top)));
                    sent++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        fault_cnt     = 0;
        list_len      = 0;
        steps_reg     = STEPS_W'(STEPS_RESET);
        send_gap_pct  = 0;
        out_stall_pct = 0;
        quiet_cycles  = 0;

        repeat (RESET_CYC) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_list();
        test_single_point();
        test_full_list();
        test_restart();
        test_zero_steps();

        test_random_curves(0, 0, 10'd1023);
        test_random_curves(51, 0, 10'd1);
        test_random_curves(0, 51, 10'($urandom_range(2, 1022)));
        test_random_curves(36, 36, 10'(STEPS_RESET));

        // Drain, then linger long enough to catch any stray result
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_answers.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);

        if (fault_cnt == 0 && pending_answers.size() == 0) begin
            $display("[bezier_curve_point_generator_core] OK");
        end else begin
            $display("[bezier_curve_point_generator_core] ERROR");
        end
        $finish;
    end

endmodule

// ===== bezier_curve_point_generator_core.f =====
rtl/bcpg_pkg.sv
rtl/bcpg_ram.sv
rtl/bcpg_ctrl.sv
rtl/bcpg_dp.sv
rtl/bezier_curve_point_generator_core.sv
bench/testbench.sv
